/* src/wht_pkg.sv */
// shared types, mode and display codes and the digit split for the thermostat
// no dependencies
`default_nettype none

package wht_pkg;

    localparam logic [2:0] MODE_OFF       = 3'd0;
    localparam logic [2:0] MODE_OPERATION = 3'd1;
    localparam logic [2:0] MODE_NORMAL    = 3'd2;
    localparam logic [2:0] MODE_SET       = 3'd3;
    localparam logic [2:0] MODE_RESET     = 3'd4;

    localparam logic [1:0] DRIVE_OFF  = 2'd0;
    localparam logic [1:0] DRIVE_HEAT = 2'd1;
    localparam logic [1:0] DRIVE_COOL = 2'd2;

    localparam logic [1:0] SHOW_OFF    = 2'd0;
    localparam logic [1:0] SHOW_STEADY = 2'd1;
    localparam logic [1:0] SHOW_BLINK  = 2'd2;

    localparam logic [7:0] TARGET_RESET = 8'd60;
    localparam logic [5:0] BAND_RESET   = 6'd5;
    localparam logic [4:0] STEP_RESET   = 5'd5;
    localparam logic [7:0] UPPER_RESET  = 8'd70;
    localparam logic [7:0] LOWER_RESET  = 8'd40;
    localparam logic [7:0] TIMEOUT_RESET = 8'd25;

    localparam int IN_W  = 11;
    localparam int OUT_W = 26;

    // configuration register indexes
    localparam logic [2:0] REG_BAND    = 3'd0;
    localparam logic [2:0] REG_STEP    = 3'd1;
    localparam logic [2:0] REG_UPPER   = 3'd2;
    localparam logic [2:0] REG_LOWER   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    typedef struct packed {
        logic [5:0] band;
        logic [4:0] step;
        logic [7:0] upper;
        logic [7:0] lower;
        logic [7:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] prev_mode;
        logic [7:0] held_temp;
        logic [7:0] target;
        logic [7:0] idle_count;
        logic [1:0] drive;
        logic [1:0] led;
        logic [1:0] disp_mode;
        logic [3:0] disp_ones;
        logic [3:0] disp_tens;
    } ctl_state_t;

    typedef struct packed {
        logic [7:0] saved_target;
        logic       save_request;
        logic [3:0] digit_tens;
        logic [3:0] digit_ones;
        logic [1:0] display_mode;
        logic [1:0] led_mode;
        logic [1:0] drive;
        logic [2:0] mode_now;
    } result_t;

    // returns {tens, ones}; divide by ten as multiply by 205 and shift by 11
    function automatic logic [7:0] split_digits(input logic [7:0] v);
        logic [18:0] prod;
        logic [4:0]  q;
        logic [7:0]  rem;
        logic [4:0]  tens;
        prod = 19'(v) * 19'd205;
        q    = prod[15:11];
        rem  = v - 8'(8'(q) * 8'd10);
        if (q >= 5'd20)
            tens = q - 5'd20;
        else if (q >= 5'd10)
            tens = q - 5'd10;
        else
            tens = q;
        return {tens[3:0], rem[3:0]};
    endfunction

endpackage

`default_nettype wire

/* src/wht_step.sv */
// next-state and result logic for one thermostat tick
// depends on wht_pkg
`default_nettype none

module wht_step
    import wht_pkg::*;
(
    input  wire ctl_state_t cur,
    input  wire cfg_t       cfg,
    input  wire logic       set_pressed,
    input  wire logic       minus_pressed,
    input  wire logic       plus_pressed,
    input  wire logic [7:0] temperature,
    output ctl_state_t      nxt,
    output result_t         res
);

    logic signed [9:0] low_thr;
    logic [8:0]        high_thr;
    logic              plus_ok;
    logic              minus_ok;
    logic [8:0]        plus_sum;
    logic [7:0]        tgt_plus;
    logic [7:0]        tgt_final;
    logic [7:0]        idle_before;
    logic [7:0]        digits;
    logic              save;

    always_comb
    begin
        low_thr  = $signed({2'b00, cur.target}) - $signed({4'b0000, cfg.band});
        high_thr = {1'b0, cur.target} + {3'b000, cfg.band};

        plus_ok  = plus_pressed && (cur.target <= cfg.upper);
        plus_sum = {1'b0, cur.target} + {4'b0000, cfg.step};
        if (!plus_ok)
            tgt_plus = cur.target;
        else if (plus_sum[8])
            tgt_plus = 8'hff;
        else
            tgt_plus = plus_sum[7:0];

        // minus sees the target after the plus step
        minus_ok = minus_pressed && (tgt_plus >= cfg.lower);
        if (!minus_ok)
            tgt_final = tgt_plus;
        else if (tgt_plus >= {3'b000, cfg.step})
            tgt_final = tgt_plus - {3'b000, cfg.step};
        else
            tgt_final = 8'd0;

        idle_before = (plus_ok || minus_ok) ? 8'd0 : cur.idle_count;

        nxt  = cur;
        save = 1'b0;
        digits = 8'd0;

        case (cur.mode)
            MODE_OPERATION:
            begin
                nxt.held_temp = temperature;
                if ($signed({2'b00, temperature}) <= low_thr)
                begin
                    nxt.drive = DRIVE_HEAT;
                    nxt.led   = SHOW_BLINK;
                end
                else if ({1'b0, temperature} >= high_thr)
                begin
                    nxt.drive = DRIVE_COOL;
                    nxt.led   = SHOW_STEADY;
                end
                nxt.mode = (cur.prev_mode == MODE_SET) ? MODE_SET : MODE_NORMAL;
            end
            MODE_NORMAL:
            begin
                nxt.prev_mode = MODE_NORMAL;
                digits        = split_digits(cur.held_temp);
                nxt.disp_mode = SHOW_STEADY;
                nxt.disp_ones = digits[3:0];
                nxt.disp_tens = digits[7:4];
                if (minus_pressed || plus_pressed)
                    nxt.mode = MODE_SET;
                else if (set_pressed)
                    nxt.mode = MODE_RESET;
                else
                    nxt.mode = MODE_OPERATION;
            end
            MODE_SET:
            begin
                nxt.prev_mode = MODE_SET;
                // digits show the target before this tick's presses
                digits        = split_digits(cur.target);
                nxt.disp_mode = SHOW_BLINK;
                nxt.disp_ones = digits[3:0];
                nxt.disp_tens = digits[7:4];
                nxt.target    = tgt_final;
                nxt.mode      = set_pressed ? MODE_RESET : MODE_OPERATION;
                nxt.idle_count = (idle_before == 8'hff) ? idle_before
                                                        : idle_before + 8'd1;
                if (idle_before >= cfg.timeout)
                begin
                    nxt.idle_count = 8'd0;
                    save           = 1'b1;
                    nxt.mode       = MODE_NORMAL;
                end
            end
            MODE_RESET:
            begin
                nxt.drive      = DRIVE_OFF;
                nxt.led        = SHOW_OFF;
                nxt.disp_mode  = SHOW_OFF;
                nxt.disp_ones  = 4'd0;
                nxt.disp_tens  = 4'd0;
                save           = 1'b1;
                nxt.idle_count = 8'd0;
                nxt.mode       = MODE_OFF;
                nxt.prev_mode  = MODE_OFF;
            end
            default:
            begin
                nxt.mode = set_pressed ? MODE_OPERATION : MODE_OFF;
            end
        endcase

        res.mode_now     = nxt.mode;
        res.drive        = nxt.drive;
        res.led_mode     = nxt.led;
        res.display_mode = nxt.disp_mode;
        res.digit_ones   = (nxt.disp_mode == SHOW_OFF) ? 4'd0 : nxt.disp_ones;
        res.digit_tens   = (nxt.disp_mode == SHOW_OFF) ? 4'd0 : nxt.disp_tens;
        res.save_request = save;
        res.saved_target = save ? nxt.target : 8'd0;
    end

endmodule

`default_nettype wire

/* src/water_heater_thermostat_fsm_core.sv */
// thermostat top level: input register, step logic, result register, config port
// depends on wht_pkg and wht_step
// requests pass the input register, then the result register once the output is free
// throughput: one request per cycle unless m_tready stalls the output
// reset: rst_n clears the mode state, the valids and the config registers to
// their defaults (band 5, step 5, limits 70 and 40, timeout 25, target 60)
`default_nettype none

module water_heater_thermostat_fsm_core
    import wht_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // slave side, tdata: set_pressed, minus_pressed, plus_pressed, temperature[7:0]
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [15:0]        s_tdata,
    // master side, tdata: mode_now[2:0], drive[1:0], led_mode[1:0], display_mode[1:0],
    // digit_ones[3:0], digit_tens[3:0], save_request, saved_target[7:0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    ctl_state_t        state_reg;
    ctl_state_t        state_next;
    cfg_t              cfg_reg;
    result_t           res;
    logic              advance;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - OUT_W){1'b0}}, out_data_reg};
    assign pready   = 1'b1;
    assign reg_idx  = paddr[4:2];
    assign cfg_wr   = psel && penable && pwrite && pready;

    wht_step u_step (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .set_pressed   (in_data_reg[0]),
        .minus_pressed (in_data_reg[1]),
        .plus_pressed  (in_data_reg[2]),
        .temperature   (in_data_reg[10:3]),
        .nxt           (state_next),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: MODE_OFF, prev_mode: MODE_OFF, held_temp: 8'd0,
                               target: TARGET_RESET, idle_count: 8'd0,
                               drive: DRIVE_OFF, led: SHOW_OFF, disp_mode: SHOW_OFF,
                               disp_ones: 4'd0, disp_tens: 4'd0};
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata[IN_W-1:0];
        if (advance)
            out_data_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{band: BAND_RESET, step: STEP_RESET, upper: UPPER_RESET,
                         lower: LOWER_RESET, timeout: TIMEOUT_RESET};
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_BAND:    cfg_reg.band    <= pwdata[5:0];
                REG_STEP:    cfg_reg.step    <= pwdata[4:0];
                REG_UPPER:   cfg_reg.upper   <= pwdata[7:0];
                REG_LOWER:   cfg_reg.lower   <= pwdata[7:0];
                REG_TIMEOUT: cfg_reg.timeout <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BAND:    prdata = {26'd0, cfg_reg.band};
            REG_STEP:    prdata = {27'd0, cfg_reg.step};
            REG_UPPER:   prdata = {24'd0, cfg_reg.upper};
            REG_LOWER:   prdata = {24'd0, cfg_reg.lower};
            REG_TIMEOUT: prdata = {24'd0, cfg_reg.timeout};
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* tb/sv/water_heater_thermostat_fsm_core_test.sv */
`timescale 1ns / 100ps
// self-checking bench for the thermostat core: stream requests in, checked results out
// holds its own tick-by-tick predictor of the mode machine; depends on wht_pkg and the core

module water_heater_thermostat_fsm_core_test;
    import wht_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CHUNK_TICKS = 105;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // set_pressed, minus_pressed, plus_pressed, temperature[7:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // mode_now[2:0], drive[1:0], led_mode[1:0], display_mode[1:0],
                               // digit_ones[3:0], digit_tens[3:0], save_request, saved_target[7:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    water_heater_thermostat_fsm_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    class thermostat_tracker;
        logic [5:0] band;
        logic [4:0] step;
        logic [7:0] upper;
        logic [7:0] lower;
        logic [7:0] timeout;
        logic [2:0] mode;
        logic [2:0] prev_mode;
        logic [7:0] held_temp;
        logic [7:0] target;
        logic [7:0] idle_count;
        logic [1:0] drive;
        logic [1:0] led;
        logic [1:0] disp_mode;
        logic [7:0] shown_value;
        result_t    pending_results[$];
        int         errors;
        int         checked;
        int         saves;

        function new();
            band        = BAND_RESET;
            step        = STEP_RESET;
            upper       = UPPER_RESET;
            lower       = LOWER_RESET;
            timeout     = TIMEOUT_RESET;
            mode        = MODE_OFF;
            prev_mode   = MODE_OFF;
            held_temp   = '0;
            target      = TARGET_RESET;
            idle_count  = '0;
            drive       = DRIVE_OFF;
            led         = SHOW_OFF;
            disp_mode   = SHOW_OFF;
            shown_value = '0;
            errors      = 0;
            checked     = 0;
            saves       = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_BAND:    band    = value[5:0];
                REG_STEP:    step    = value[4:0];
                REG_UPPER:   upper   = value[7:0];
                REG_LOWER:   lower   = value[7:0];
                REG_TIMEOUT: timeout = value[7:0];
                default: ;
            endcase
        endfunction

        // advance the mode machine by one tick and queue the result it produces
        function void note_tick(bit set_b, bit minus_b, bit plus_b, logic [7:0] temp);
            result_t    r;
            int         low_th;
            int         high_th;
            int         sum;
            logic [7:0] idle_prior;
            r = '0;
            case (mode)
                MODE_OPERATION:
                begin
                    low_th    = int'(target) - int'(band);
                    high_th   = int'(target) + int'(band);
                    held_temp = temp;
                    if (int'(temp) <= low_th)
                    begin
                        drive = DRIVE_HEAT;
                        led   = SHOW_BLINK;
                    end
                    else if (int'(temp) >= high_th)
                    begin
                        drive = DRIVE_COOL;
                        led   = SHOW_STEADY;
                    end
                    mode = (prev_mode == MODE_SET) ? MODE_SET : MODE_NORMAL;
                end
                MODE_NORMAL:
                begin
                    prev_mode   = MODE_NORMAL;
                    disp_mode   = SHOW_STEADY;
                    shown_value = held_temp;
                    if (minus_b || plus_b)
                        mode = MODE_SET;
                    else if (set_b)
                        mode = MODE_RESET;
                    else
                        mode = MODE_OPERATION;
                end
                MODE_SET:
                begin
                    prev_mode   = MODE_SET;
                    disp_mode   = SHOW_BLINK;
                    shown_value = target;
                    // plus goes first, minus then sees the new target
                    if (plus_b && target <= upper)
                    begin
                        sum        = int'(target) + int'(step);
                        target     = (sum > 255) ? 8'd255 : 8'(sum);
                        idle_count = '0;
                    end
                    if (minus_b && target >= {3'b000, step})
                    begin
                        if (target >= lower)
                        begin
                            target     = target - {3'b000, step};
                            idle_count = '0;
                        end
                    end
                    else if (minus_b && target >= lower)
                    begin
                        target     = '0;
                        idle_count = '0;
                    end
                    mode       = set_b ? MODE_RESET : MODE_OPERATION;
                    idle_prior = idle_count;
                    if (idle_count != 8'd255)
                        idle_count = idle_count + 8'd1;
                    if (idle_prior >= timeout)
                    begin
                        idle_count     = '0;
                        r.save_request = 1'b1;
                        r.saved_target = target;
                        mode           = MODE_NORMAL;
                    end
                end
                MODE_RESET:
                begin
                    drive          = DRIVE_OFF;
                    led            = SHOW_OFF;
                    disp_mode      = SHOW_OFF;
                    shown_value    = '0;
                    r.save_request = 1'b1;
                    r.saved_target = target;
                    idle_count     = '0;
                    mode           = MODE_OFF;
                    prev_mode      = MODE_OFF;
                end
                default:
                    mode = set_b ? MODE_OPERATION : MODE_OFF;
            endcase
            r.mode_now     = mode;
            r.drive        = drive;
            r.led_mode     = led;
            r.display_mode = disp_mode;
            if (disp_mode != SHOW_OFF)
            begin
                r.digit_ones = 4'(shown_value % 10);
                r.digit_tens = 4'((shown_value / 10) % 10);
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [31:0] data);
            result_t got;
            result_t want;
            got = result_t'(data[OUT_W-1:0]);
            checked++;
            if (got.save_request)
                saves++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            want = pending_results.pop_front();
            compare_field("mode_now", want.mode_now, got.mode_now);
            compare_field("drive", want.drive, got.drive);
            compare_field("led_mode", want.led_mode, got.led_mode);
            compare_field("display_mode", want.display_mode, got.display_mode);
            compare_field("digit_ones", want.digit_ones, got.digit_ones);
            compare_field("digit_tens", want.digit_tens, got.digit_tens);
            compare_field("save_request", want.save_request, got.save_request);
            compare_field("saved_target", want.saved_target, got.saved_target);
        endfunction
    endclass

    thermostat_tracker tracker;
    int tx_idle_pct;
    int rx_idle_pct;
    int ticks_sent;
    int settings_used;
    int quiet_left;
    int cycle_count;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task send_tick(input bit set_b, input bit minus_b, input bit plus_b, input logic [7:0] temp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, temp, plus_b, minus_b, set_b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_tick(set_b, minus_b, plus_b, temp);
        ticks_sent++;
    endtask

    // stop sending and let every outstanding request come back
    task settle();
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    task apply_settings(input int band_v, input int step_v, input int upper_v,
                        input int lower_v, input int timeout_v);
        settle();
        write_reg(REG_BAND, band_v);
        write_reg(REG_STEP, step_v);
        write_reg(REG_UPPER, upper_v);
        write_reg(REG_LOWER, lower_v);
        write_reg(REG_TIMEOUT, timeout_v);
        settings_used++;
    endtask

    // mostly button sequences that walk the mode machine, with quiet runs for the
    // set-mode timeout and a share of pure noise
    task random_tick();
        bit set_b;
        bit minus_b;
        bit plus_b;
        int spread;
        int t;
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(99) < 4)
            quiet_left = $urandom_range(20, 70);
        set_b   = $urandom_range(1);
        minus_b = $urandom_range(1);
        plus_b  = $urandom_range(1);
        if ($urandom_range(99) >= 10)
        begin
            case (tracker.mode)
                MODE_OFF:
                    set_b = (quiet_left > 0) || ($urandom_range(99) < 70);
                MODE_NORMAL, MODE_SET:
                begin
                    if (quiet_left > 0)
                    begin
                        set_b   = 1'b0;
                        minus_b = 1'b0;
                        plus_b  = 1'b0;
                    end
                    else
                    begin
                        set_b   = ($urandom_range(99) < 5);
                        minus_b = ($urandom_range(99) < 28);
                        plus_b  = ($urandom_range(99) < 28);
                    end
                end
                default: ;
            endcase
        end
        if ($urandom_range(99) < 60)
        begin
            spread = int'(tracker.band) + 3;
            t = int'(tracker.target) + int'($urandom_range(0, 2 * spread)) - spread;
            if (t < 0)
                t = 0;
            if (t > 255)
                t = 255;
        end
        else
            t = $urandom_range(0, 255);
        send_tick(set_b, minus_b, plus_b, 8'(t));
    endtask

    task run_chunk(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (CHUNK_TICKS) random_tick();
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_pct   = 28;
        rx_idle_pct   = 78;
        ticks_sent    = 0;
        settings_used = 1;
        quiet_left    = 0;
        cycle_count   = 0;
        tracker       = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through every mode at the reset settings
        send_tick(0, 0, 0, 8'd0);
        send_tick(1, 0, 0, 8'd0);
        send_tick(0, 1, 1, 8'd0);      // heat at the bottom of the range
        send_tick(0, 0, 0, 8'd255);
        send_tick(0, 0, 0, 8'd255);    // cool at the top
        send_tick(0, 0, 1, 8'd100);
        send_tick(0, 1, 1, 8'd57);     // plus then minus in one tick
        send_tick(0, 0, 0, 8'd57);     // inside the band, drive held
        send_tick(0, 0, 1, 8'd0);
        send_tick(0, 0, 0, 8'd60);
        send_tick(0, 1, 0, 8'd0);
        send_tick(0, 0, 0, 8'd55);     // exactly on the lower threshold
        send_tick(1, 0, 0, 8'd0);
        send_tick(0, 0, 0, 8'd0);      // reset mode saves and blanks
        send_tick(0, 1, 1, 8'd200);
        send_tick(1, 1, 1, 8'd65);
        send_tick(0, 0, 0, 8'd65);     // exactly on the upper threshold
        send_tick(1, 0, 0, 8'd0);
        send_tick(1, 0, 0, 8'd0);
        send_tick(1, 0, 0, 8'd0);
        send_tick(0, 0, 0, 8'd128);
        send_tick(1, 1, 0, 8'd0);      // a step button wins over set in normal
        send_tick(0, 0, 0, 8'd0);

        apply_settings(0, 1, 200, 0, 0);
        run_chunk(28, 78);
        apply_settings(50, 20, 0, 200, 255);
        run_chunk(28, 78);
        // full-width values: negative lower threshold and target saturating at 255
        apply_settings(63, 31, 255, 255, 1);
        run_chunk(78, 28);
        // big step with no lower limit drives the target to zero
        apply_settings($urandom_range(0, 50), 31, 100, 0, 3);
        run_chunk(78, 28);
        apply_settings($urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 8));
        run_chunk(0, 0);
        apply_settings(5, 5, 70, 40, 25);
        run_chunk(0, 0);

        settle();
        repeat (8) @(posedge clk);
        if (tracker.pending_results.size() != 0)
        begin
            $display("%0d results never arrived", tracker.pending_results.size());
            tracker.errors++;
        end
        $display("sent %0d ticks under %0d register settings, %0d results checked",
                 ticks_sent, settings_used, tracker.checked);
        $display("%0d save requests seen, %0d mismatches", tracker.saves, tracker.errors);
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
